FILE: hw/rtl/ugb_pkg.sv
// Shared types and constants of the uniform grid broad-phase block.
// No dependencies.
`default_nettype none
package ugb_pkg;

    localparam int CELL_SHIFT_DEF    = 5;
    localparam int ROW_SHIFT_DEF     = 4;
    localparam int CELL_COUNT_DEF    = 256;
    localparam int CELL_CAPACITY_DEF = 8;
    localparam int ENTITY_COUNT_DEF  = 256;

    localparam int QUERY_LIMIT = 64;
    localparam int ID_W        = 8;
    localparam int COORD_W     = 12;   // holds any clamped cell coordinate
    localparam int ACT_W       = 2;
    localparam int RES_CNT_W   = 7;    // 0..QUERY_LIMIT

    localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACT_W-1:0] ACT_QUERY  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_CLEAR  = 2'd2;

    // classified command, front to back
    typedef struct packed {
        logic [ACT_W-1:0]   action;
        logic [ID_W-1:0]    id;
        logic               empty;   // no cell with non-negative coordinates in range
        logic [COORD_W-1:0] sx;
        logic [COORD_W-1:0] ex;
        logic [COORD_W-1:0] sy;
        logic [COORD_W-1:0] ey;
    } t_cmd;

    // back status seen by the front
    typedef struct packed {
        logic init_busy;   // clearing pass after reset in progress
        logic pop;         // back takes the queue head this cycle
    } t_bstat;

endpackage
`default_nettype wire

FILE: hw/rtl/uniform_grid_broadphase.sv
// Top level of the uniform grid broad-phase block: front end, queue, back end.
// Depends on ugb_pkg, ugb_front, ugb_back.
// Each covered cell in the grid has its fill count read; cells beyond are skipped.
// A query reads every entry of each cell, and a clear sweeps all fill counts.
// The back end holds one transaction in flight, walking its cells over the
// memories; the front queue holds two more. One query in 255 adds a pass that
// wipes the seen marks.
// Reset: synchronous, active low; a clearing pass then runs over the fill and seen
// memories, and no input transaction is accepted until it ends.
`default_nettype none
module uniform_grid_broadphase import ugb_pkg::*; #(
    parameter int CELL_SHIFT    = CELL_SHIFT_DEF,
    parameter int ROW_SHIFT     = ROW_SHIFT_DEF,
    parameter int CELL_COUNT    = CELL_COUNT_DEF,
    parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
    parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [ACT_W-1:0]   i_action,
    input  wire logic [ID_W-1:0]    i_entity_id,
    input  wire logic signed [15:0] i_pos_x,
    input  wire logic signed [15:0] i_pos_y,
    input  wire logic [14:0]        i_extent_x,
    input  wire logic [14:0]        i_extent_y,
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic [ID_W-1:0]         o_result_id,
    output logic                    o_found,
    output logic                    o_overflow,
    output logic                    o_last
);

    // classified commands flow front to back; status flows back
    logic   cmd_valid;
    t_cmd   cmd;
    t_bstat stat;

    ugb_front #(
        .CELL_SHIFT (CELL_SHIFT),
        .CELL_COUNT (CELL_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_action    (i_action),
        .i_entity_id (i_entity_id),
        .i_pos_x     (i_pos_x),
        .i_pos_y     (i_pos_y),
        .i_extent_x  (i_extent_x),
        .i_extent_y  (i_extent_y),
        .i_stat      (stat),
        .o_cmd_valid (cmd_valid),
        .o_cmd       (cmd)
    );

    // back end owns the cell memories, seen memory and result register
    ugb_back #(
        .ROW_SHIFT     (ROW_SHIFT),
        .CELL_COUNT    (CELL_COUNT),
        .CELL_CAPACITY (CELL_CAPACITY),
        .ENTITY_COUNT  (ENTITY_COUNT)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_result_id (o_result_id),
        .o_found     (o_found),
        .o_overflow  (o_overflow),
        .o_last      (o_last)
    );

endmodule
`default_nettype wire

FILE: hw/rtl/ugb_front.sv
// Front end: accepts transactions, forms clamped cell ranges, two-entry queue.
// Depends on ugb_pkg.
`default_nettype none
module ugb_front import ugb_pkg::*; #(
    parameter int CELL_SHIFT = CELL_SHIFT_DEF,
    parameter int CELL_COUNT = CELL_COUNT_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_ready,
    input  wire logic [ACT_W-1:0]    i_action,
    input  wire logic [ID_W-1:0]     i_entity_id,
    input  wire logic signed [15:0]  i_pos_x,
    input  wire logic signed [15:0]  i_pos_y,
    input  wire logic [14:0]         i_extent_x,
    input  wire logic [14:0]         i_extent_y,
    input  wire t_bstat              i_stat,
    output logic                     o_cmd_valid,
    output t_cmd                     o_cmd
);

    localparam logic signed [17:0] CMAX = 18'(CELL_COUNT - 1);

    logic signed [17:0] lo_x, hi_x, lo_y, hi_y;
    logic signed [17:0] cl_x, ch_x, cl_y, ch_y;
    t_cmd               cmd;

    always_comb begin
        lo_x = 18'(i_pos_x) - $signed({3'b000, i_extent_x});
        hi_x = 18'(i_pos_x) + $signed({3'b000, i_extent_x});
        lo_y = 18'(i_pos_y) - $signed({3'b000, i_extent_y});
        hi_y = 18'(i_pos_y) + $signed({3'b000, i_extent_y});
        cl_x = lo_x >>> CELL_SHIFT;
        ch_x = hi_x >>> CELL_SHIFT;
        cl_y = lo_y >>> CELL_SHIFT;
        ch_y = hi_y >>> CELL_SHIFT;
        cmd.action = i_action;
        cmd.id     = i_entity_id;
        cmd.empty  = (ch_x < 0) || (cl_x > CMAX) || (ch_y < 0) || (cl_y > CMAX);
        cmd.sx     = (cl_x < 0) ? '0 : cl_x[COORD_W-1:0];
        cmd.sy     = (cl_y < 0) ? '0 : cl_y[COORD_W-1:0];
        cmd.ex     = (ch_x > CMAX) ? CMAX[COORD_W-1:0] : ch_x[COORD_W-1:0];
        cmd.ey     = (ch_y > CMAX) ? CMAX[COORD_W-1:0] : ch_y[COORD_W-1:0];
    end

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt, n_cnt;
    logic       push;

    assign o_in_ready  = (r_cnt != 2'd2) && !i_stat.init_busy;
    assign push        = i_in_valid && o_in_ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];

    always_comb begin
        n_cnt = r_cnt + 2'(push) - 2'(i_stat.pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (i_stat.pop) r_rp <= ~r_rp;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= cmd;
    end

endmodule
`default_nettype wire

FILE: hw/rtl/ugb_back.sv
// Back end: walks covered cells over the fill and entry memories, emits results.
// Depends on ugb_pkg.
`default_nettype none
module ugb_back import ugb_pkg::*; #(
    parameter int ROW_SHIFT     = ROW_SHIFT_DEF,
    parameter int CELL_COUNT    = CELL_COUNT_DEF,
    parameter int CELL_CAPACITY = CELL_CAPACITY_DEF,
    parameter int ENTITY_COUNT  = ENTITY_COUNT_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_cmd_valid,
    input  wire t_cmd            i_cmd,
    output t_bstat               o_stat,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [ID_W-1:0]      o_result_id,
    output logic                 o_found,
    output logic                 o_overflow,
    output logic                 o_last
);

    localparam int HW = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
    localparam int IW = (CELL_CAPACITY > 1) ? $clog2(CELL_CAPACITY) : 1;
    localparam int FW = $clog2(CELL_CAPACITY + 1);
    localparam int XW = 2 * COORD_W;
    localparam int EW = 8;              // query epoch mark in the seen memory

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_SWEEP = 4'd1;
    localparam logic [3:0] S_CELL  = 4'd2;
    localparam logic [3:0] S_FWAIT = 4'd3;
    localparam logic [3:0] S_FUSE  = 4'd4;
    localparam logic [3:0] S_ERQ   = 4'd5;
    localparam logic [3:0] S_ERD   = 4'd6;
    localparam logic [3:0] S_FIN   = 4'd7;
    localparam logic [3:0] S_SCLR  = 4'd8;
    localparam logic [3:0] S_ECHK  = 4'd9;

    logic [3:0]           r_state, n_state;
    logic                 r_init, n_init;
    logic [ACT_W-1:0]     r_act, n_act;
    logic [ID_W-1:0]      r_id, n_id;
    logic [COORD_W-1:0]   r_sx, n_sx, r_ex, n_ex, r_ey, n_ey, r_x, n_x, r_y, n_y;
    logic [HW-1:0]        r_h, n_h;
    logic [IW-1:0]        r_i, n_i;
    logic [RES_CNT_W-1:0] r_n, n_n;
    logic [ID_W-1:0]      r_pend, n_pend;
    logic                 r_pend_v, n_pend_v;
    logic                 r_ovf, n_ovf;
    logic [EW-1:0]        r_ep, n_ep;
    logic [ID_W-1:0]      r_sh, n_sh;
    logic                 r_ov, n_ov;
    logic [ID_W-1:0]      r_oid, n_oid;
    logic                 r_ofound, n_ofound, r_oovf, n_oovf, r_olast, n_olast;

    logic [FW-1:0]        r_fill_mem [CELL_COUNT];
    logic [ID_W-1:0]      r_ent_mem  [CELL_COUNT << IW];
    logic [EW-1:0]        r_seen_mem [1 << ID_W];
    logic [FW-1:0]        r_fq;
    logic [ID_W-1:0]      r_eq;
    logic [EW-1:0]        r_sq;

    logic                 fill_we, ent_we, seen_we;
    logic [FW-1:0]        fill_wd;
    logic [ID_W-1:0]      seen_wa;
    logic [EW-1:0]        seen_wd;
    logic [XW-1:0]        hwide;
    logic                 h_ok, can_out, adv, newid, pop;

    assign hwide   = {{COORD_W{1'b0}}, r_x} | ({{COORD_W{1'b0}}, r_y} << ROW_SHIFT);
    assign h_ok    = hwide < XW'(CELL_COUNT);
    assign can_out = !r_ov || i_out_ready;
    // an id is seen in this query when its mark equals the current epoch
    assign newid   = (32'(r_eq) < 32'(ENTITY_COUNT)) && (r_sq != r_ep);

    assign o_stat.init_busy = r_init;
    assign o_stat.pop       = pop;

    always_comb begin
        n_state = r_state;  n_init = r_init;  n_act = r_act;  n_id = r_id;
        n_sx = r_sx;  n_ex = r_ex;  n_ey = r_ey;  n_x = r_x;  n_y = r_y;
        n_h = r_h;  n_i = r_i;  n_n = r_n;  n_pend = r_pend;  n_pend_v = r_pend_v;
        n_ovf = r_ovf;  n_ep = r_ep;  n_sh = r_sh;
        n_ov = r_ov && !i_out_ready;
        n_oid = r_oid;  n_ofound = r_ofound;  n_oovf = r_oovf;  n_olast = r_olast;
        fill_we = 1'b0;  fill_wd = r_fq + FW'(1);  ent_we = 1'b0;
        seen_we = 1'b0;  seen_wa = r_eq;  seen_wd = r_ep;
        adv = 1'b0;  pop = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    pop      = 1'b1;
                    n_act    = i_cmd.action;
                    n_id     = i_cmd.id;
                    n_sx     = i_cmd.sx;  n_ex = i_cmd.ex;  n_ey = i_cmd.ey;
                    n_x      = i_cmd.sx;  n_y  = i_cmd.sy;
                    n_h      = '0;
                    n_n      = '0;
                    n_pend_v = 1'b0;
                    n_ovf    = 1'b0;
                    unique case (i_cmd.action)
                        ACT_INSERT: n_state = (i_cmd.empty ||
                            32'(i_cmd.id) >= 32'(ENTITY_COUNT)) ? S_FIN : S_CELL;
                        ACT_QUERY: begin
                            if (i_cmd.empty) begin
                                n_state = S_FIN;
                            end else if (r_ep == '1) begin
                                // epochs used up: wipe the seen marks first
                                n_sh    = '0;
                                n_state = S_SCLR;
                            end else begin
                                n_ep    = r_ep + EW'(1);
                                n_state = S_CELL;
                            end
                        end
                        ACT_CLEAR: n_state = S_SWEEP;
                        default:   n_state = S_FIN;
                    endcase
                end
            end
            S_SWEEP: begin
                fill_we = 1'b1;
                fill_wd = '0;
                if (r_h == HW'(CELL_COUNT - 1)) begin
                    n_sh    = '0;
                    n_state = r_init ? S_SCLR : S_FIN;
                end else begin
                    n_h = r_h + HW'(1);
                end
            end
            S_SCLR: begin
                seen_we = 1'b1;
                seen_wa = r_sh;
                seen_wd = '0;
                if (r_sh == '1) begin
                    n_init  = 1'b0;
                    n_ep    = r_init ? '0 : EW'(1);
                    n_state = r_init ? S_IDLE : S_CELL;
                end else begin
                    n_sh = r_sh + ID_W'(1);
                end
            end
            S_CELL: begin
                if (h_ok) begin
                    n_h     = hwide[HW-1:0];
                    n_state = S_FWAIT;
                end else begin
                    adv = 1'b1;
                end
            end
            S_FWAIT: n_state = S_FUSE;
            S_FUSE: begin
                if (r_act == ACT_INSERT) begin
                    if (r_fq >= FW'(CELL_CAPACITY)) begin
                        n_ovf = 1'b1;
                    end else begin
                        ent_we  = 1'b1;
                        fill_we = 1'b1;
                    end
                    adv = 1'b1;
                end else if (r_fq == '0) begin
                    adv = 1'b1;
                end else begin
                    n_i     = '0;
                    n_state = S_ERQ;
                end
            end
            S_ERQ: n_state = S_ERD;
            // entry id in hand, its seen mark is being read
            S_ERD: n_state = S_ECHK;
            S_ECHK: begin
                if (newid && r_n == RES_CNT_W'(QUERY_LIMIT)) begin
                    n_ovf   = 1'b1;
                    n_state = S_FIN;
                end else if (!(newid && r_pend_v && !can_out)) begin
                    if (newid) begin
                        if (r_pend_v) begin
                            n_ov = 1'b1;  n_oid = r_pend;  n_ofound = 1'b1;
                            n_oovf = 1'b0;  n_olast = 1'b0;
                        end
                        n_pend   = r_eq;
                        n_pend_v = 1'b1;
                        seen_we  = 1'b1;
                        n_n      = r_n + RES_CNT_W'(1);
                    end
                    if ((FW+1)'(r_i) + (FW+1)'(1) < (FW+1)'(r_fq)) begin
                        n_i     = r_i + IW'(1);
                        n_state = S_ERQ;
                    end else begin
                        adv = 1'b1;
                    end
                end
            end
            S_FIN: begin
                if (can_out) begin
                    n_ov    = 1'b1;
                    n_olast = 1'b1;
                    if (r_act == ACT_QUERY && r_pend_v) begin
                        n_oid = r_pend;  n_ofound = 1'b1;  n_oovf = r_ovf;
                    end else begin
                        n_oid = '0;  n_ofound = 1'b0;
                        n_oovf = (r_act == ACT_INSERT) ? r_ovf : 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        // step to the next covered cell, row by row
        if (adv) begin
            if (r_x == r_ex) begin
                if (r_y == r_ey) begin
                    n_state = S_FIN;
                end else begin
                    n_y     = r_y + COORD_W'(1);
                    n_x     = r_sx;
                    n_state = S_CELL;
                end
            end else begin
                n_x     = r_x + COORD_W'(1);
                n_state = S_CELL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_init   <= 1'b1;
            r_h      <= '0;
            r_ov     <= 1'b0;
            r_pend_v <= 1'b0;
            r_n      <= '0;
            r_ep     <= '0;
        end else begin
            r_state  <= n_state;
            r_init   <= n_init;
            r_h      <= n_h;
            r_ov     <= n_ov;
            r_pend_v <= n_pend_v;
            r_n      <= n_n;
            r_ep     <= n_ep;
        end
    end

    always_ff @(posedge i_clk) begin
        r_act <= n_act;  r_id <= n_id;
        r_sx <= n_sx;  r_ex <= n_ex;  r_ey <= n_ey;  r_x <= n_x;  r_y <= n_y;
        r_i <= n_i;  r_pend <= n_pend;  r_ovf <= n_ovf;  r_sh <= n_sh;
        r_oid <= n_oid;  r_ofound <= n_ofound;  r_oovf <= n_oovf;  r_olast <= n_olast;
    end

    // fill count memory: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (fill_we) r_fill_mem[r_h] <= fill_wd;
        r_fq <= r_fill_mem[r_h];
    end

    // entry memory, addressed {cell, slot}
    always_ff @(posedge i_clk) begin
        if (ent_we) r_ent_mem[{r_h, r_fq[IW-1:0]}] <= r_id;
        r_eq <= r_ent_mem[{r_h, r_i}];
    end

    // seen memory: epoch mark per id, read at the entry just fetched
    always_ff @(posedge i_clk) begin
        if (seen_we) r_seen_mem[seen_wa] <= seen_wd;
        r_sq <= r_seen_mem[r_eq];
    end

    assign o_out_valid = r_ov;
    assign o_result_id = r_oid;
    assign o_found     = r_ofound;
    assign o_overflow  = r_oovf;
    assign o_last      = r_olast;

    a_count_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= RES_CNT_W'(QUERY_LIMIT))
        else $error("result count beyond limit");
    a_slot_in_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ERD || r_state == S_ECHK) |-> ((FW+1)'(r_i) < (FW+1)'(r_fq)))
        else $error("entry read beyond fill count");
    a_pend_counted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend_v |-> (r_n != '0))
        else $error("pending id not counted");
    a_no_pop_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_init |-> !pop)
        else $error("command taken during clearing pass");

endmodule
`default_nettype wire

FILE: dv/tb_uniform_grid_broadphase.sv
// Self-checking testbench for uniform_grid_broadphase: a queue-fed driver, a monitor and
// a cycle-free predictor of the grid contents. Depends on ugb_pkg and the block's RTL.
`timescale 1ns / 100ps
module tb_uniform_grid_broadphase;
    import ugb_pkg::*;

    localparam int CSH  = CELL_SHIFT_DEF;
    localparam int RSH  = ROW_SHIFT_DEF;
    localparam int NCEL = CELL_COUNT_DEF;
    localparam int CAP  = CELL_CAPACITY_DEF;
    localparam int NENT = ENTITY_COUNT_DEF;
    localparam int STALL_LIMIT = 1000000;
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;   // unused action code

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [ID_W-1:0]  id;
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic [14:0] wx;
        logic [14:0] wy;
    } t_txn;

    typedef struct packed {
        logic [ID_W-1:0] id;
        logic found;
        logic overflow;
        logic last;
    } t_res;

    logic clk, rst_n;
    logic in_valid, in_ready, out_valid, out_ready;
    logic [ACT_W-1:0] action;
    logic [ID_W-1:0] entity_id;
    logic signed [15:0] pos_x, pos_y;
    logic [14:0] extent_x, extent_y;
    logic [ID_W-1:0] result_id;
    logic found, overflow, last;

    uniform_grid_broadphase dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_ready(in_ready),
        .i_action(action), .i_entity_id(entity_id),
        .i_pos_x(pos_x), .i_pos_y(pos_y),
        .i_extent_x(extent_x), .i_extent_y(extent_y),
        .o_out_valid(out_valid), .i_out_ready(out_ready),
        .o_result_id(result_id), .o_found(found),
        .o_overflow(overflow), .o_last(last)
    );

    // Predictor state: mirror of the grid
    logic [ID_W-1:0] grid_ids [NCEL][CAP];
    int unsigned     grid_fill [NCEL];

    t_txn pending_txns[$];
    t_res expected_results[$];
    int   errors, watchdog, n_results, n_found, n_trunc, n_ovf;
    bit   stimulus_done, timed_out;
    bit   calm;            // long stretch with no idling

    initial begin
        clk = 0;
        forever #10 clk = ~clk;
    end

    // Append to the tail of the stimulus and expectation queues
    function automatic void add_txn(t_txn t);
        pending_txns = {pending_txns, t};
    endfunction

    function automatic void add_result(t_res r);
        expected_results = {expected_results, r};
    endfunction

    // Arithmetic (floor) shift of a 32-bit signed sum
    function automatic int floor_cell(int v);
        return v >>> CSH;
    endfunction

    // Covered cell range, clamped like the block does
    function automatic void covered_cells(t_txn t, output int sx, output int sy,
                                          output int ex, output int ey);
        int cx, cy, rx, ry;
        cx = int'(t.px); cy = int'(t.py);
        rx = int'(t.wx); ry = int'(t.wy);
        sx = floor_cell(cx - rx); sy = floor_cell(cy - ry);
        ex = floor_cell(cx + rx); ey = floor_cell(cy + ry);
        if (sx < 0) sx = 0;
        if (sy < 0) sy = 0;
        if (ex > NCEL - 1) ex = NCEL - 1;
        if (ey > NCEL - 1) ey = NCEL - 1;
    endfunction

    // Apply one accepted transaction to the grid mirror and queue the answers
    task automatic predict_grid(t_txn t);
        int sx, sy, ex, ey, h, cnt;
        bit ovf, trunc;
        bit seen [NENT];
        t_res r;
        ovf = 0; trunc = 0; cnt = 0;
        case (t.action)
            ACT_INSERT: begin
                if (int'(t.id) < NENT) begin
                    covered_cells(t, sx, sy, ex, ey);
                    for (int y = sy; y <= ey; y++)
                        for (int x = sx; x <= ex; x++) begin
                            h = x | (y << RSH);
                            if (h >= NCEL) continue;
                            if (grid_fill[h] >= CAP) begin
                                ovf = 1;
                                continue;
                            end
                            grid_ids[h][grid_fill[h]] = t.id;
                            grid_fill[h]++;
                        end
                end
                add_result('{'0, 1'b0, ovf, 1'b1});
            end
            ACT_QUERY: begin
                foreach (seen[i]) seen[i] = 0;
                covered_cells(t, sx, sy, ex, ey);
                for (int y = sy; y <= ey && !trunc; y++)
                    for (int x = sx; x <= ex && !trunc; x++) begin
                        h = x | (y << RSH);
                        if (h >= NCEL) continue;
                        for (int i = 0; i < grid_fill[h]; i++) begin
                            if (seen[grid_ids[h][i]]) continue;
                            if (cnt >= QUERY_LIMIT) begin
                                trunc = 1;
                                break;
                            end
                            seen[grid_ids[h][i]] = 1;
                            add_result('{grid_ids[h][i], 1'b1, 1'b0, 1'b0});
                            cnt++;
                        end
                    end
                if (cnt == 0) begin
                    add_result('{'0, 1'b0, 1'b0, 1'b1});
                end else begin
                    r = expected_results.pop_back();
                    r.overflow = trunc;
                    r.last = 1'b1;
                    add_result(r);
                end
            end
            default: begin
                // clear empties the grid; the unused code answers alike but keeps it
                if (t.action == ACT_CLEAR)
                    foreach (grid_fill[i]) grid_fill[i] = 0;
                add_result('{'0, 1'b0, 1'b0, 1'b1});
            end
        endcase
    endtask

    function automatic t_txn mk(logic [ACT_W-1:0] a, int id, int px, int py, int wx, int wy);
        t_txn t;
        t.action = a; t.id = id[7:0];
        t.px = px[15:0]; t.py = py[15:0];
        t.wx = wx[14:0]; t.wy = wy[14:0];
        return t;
    endfunction

    // Mostly boxes over the positive grid quadrant, so cells really fill up
    function automatic t_txn rand_txn();
        int r;
        t_txn t;
        r = $urandom_range(0, 99);
        t.action = (r < 55) ? ACT_INSERT : (r < 93) ? ACT_QUERY :
                   (r < 97) ? ACT_CLEAR : ACT_SPARE;
        t.id = ID_W'($urandom);
        if ($urandom_range(0, 9) == 0) begin
            // noise: full range of every field
            t.px = 16'($urandom); t.py = 16'($urandom);
            t.wx = 15'($urandom); t.wy = 15'($urandom);
        end else begin
            t.px = 16'($urandom_range(0, 600)) - 16'd40;
            t.py = 16'($urandom_range(0, 600)) - 16'd40;
            t.wx = 15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                    : $urandom_range(0, 40));
            t.wy = 15'(($urandom_range(0, 3) == 0) ? $urandom_range(0, 200)
                                                    : $urandom_range(0, 40));
        end
        return t;
    endfunction

    // Stimulus: directed corner cases, then random traffic
    initial begin
        add_txn(mk(ACT_QUERY, 0, 100, 100, 0, 0));           // nothing found
        add_txn(mk(ACT_INSERT, 255, 0, 0, 0, 0));            // id extreme
        add_txn(mk(ACT_INSERT, 0, 32767, 32767, 0, 0));      // far cell skipped
        add_txn(mk(ACT_INSERT, 7, -32768, -32768, 32767, 32767));
        add_txn(mk(ACT_INSERT, 9, -100, -100, 40, 40));      // negative cells
        add_txn(mk(ACT_INSERT, 3, 600, 10, 100, 5));         // aliasing by OR
        add_txn(mk(ACT_QUERY, 0, 32767, 32767, 32767, 32767));
        for (int i = 0; i < 9; i++)                          // fill one cell
            add_txn(mk(ACT_INSERT, 20 + i, 40, 40, 0, 0));
        add_txn(mk(ACT_QUERY, 0, 40, 40, 0, 0));
        for (int i = 0; i < 4; i++)                          // four ids over a wide box
            add_txn(mk(ACT_INSERT, 100 + 17 * i, 200, 200, 200, 200));
        add_txn(mk(ACT_QUERY, 0, -32768, 12, 32767, 32767));
        add_txn(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
        add_txn(mk(ACT_SPARE, 5, 1, 1, 1, 1));               // unused code
        add_txn(mk(ACT_QUERY, 0, 200, 200, 32767, 32767));
        for (int i = 0; i < 430; i++) begin
            add_txn(rand_txn());
            // periodic clears keep the grid from saturating for good
            if (i % 90 == 89) add_txn(mk(ACT_CLEAR, 0, 0, 0, 0, 0));
        end
    end

    // Reset, end of run, report
    initial begin
        errors = 0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1;
        wait (stimulus_done || timed_out);
        while (expected_results.size() != 0 && !timed_out) @(posedge clk);
        repeat (100) @(posedge clk);
        if (timed_out) begin
            $display("Verification failed");
            $finish;
        end
        if (expected_results.size() != 0) errors++;
        $display("Ran %0d results, %0d ids found, %0d truncated queries, %0d insert overflows",
                 n_results, n_found, n_trunc, n_ovf);
        if (errors == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Driver: valid held with payload until accepted
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 0;
            action <= '0; entity_id <= '0;
            pos_x <= '0; pos_y <= '0; extent_x <= '0; extent_y <= '0;
            stimulus_done <= 0;
        end else begin
            if (in_valid && in_ready) predict_grid(pending_txns.pop_front());
            if (!in_valid || in_ready) begin
                if (pending_txns.size() > (in_valid && in_ready ? 0 : 0) &&
                    (calm || $urandom_range(0, 99) >= 36) && pending_txns.size() != 0) begin
                    in_valid  <= 1;
                    action    <= pending_txns[0].action;
                    entity_id <= pending_txns[0].id;
                    pos_x     <= pending_txns[0].px;
                    pos_y     <= pending_txns[0].py;
                    extent_x  <= pending_txns[0].wx;
                    extent_y  <= pending_txns[0].wy;
                end else begin
                    in_valid <= 0;
                    if (pending_txns.size() == 0) stimulus_done <= 1;
                end
            end
        end
    end

    // Monitor, receiver back-pressure and watchdog
    always @(posedge clk) begin
        t_res got, exp_r;
        if (!rst_n) begin
            out_ready <= 0;
            watchdog <= 0; timed_out <= 0;
            n_results <= 0; n_found <= 0; n_trunc <= 0; n_ovf <= 0;
        end else begin
            // calm stretch over part of the run
            calm = (n_results > 200 && n_results < 400);
            out_ready <= calm || ($urandom_range(0, 99) >= 36);
            if (out_valid && out_ready) begin
                got = '{result_id, found, overflow, last};
                n_results <= n_results + 1;
                if (found) n_found <= n_found + 1;
                if (overflow && found) n_trunc <= n_trunc + 1;
                if (overflow && !found) n_ovf <= n_ovf + 1;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result id=%0d found=%0b ovf=%0b last=%0b",
                             $time, result_id, found, overflow, last);
                    errors++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (got.id !== exp_r.id)
                        $display("%0t: result_id expected %0d actual %0d",
                                 $time, exp_r.id, got.id);
                    if (got.found !== exp_r.found)
                        $display("%0t: found expected %0b actual %0b",
                                 $time, exp_r.found, got.found);
                    if (got.overflow !== exp_r.overflow)
                        $display("%0t: overflow expected %0b actual %0b",
                                 $time, exp_r.overflow, got.overflow);
                    if (got.last !== exp_r.last)
                        $display("%0t: last expected %0b actual %0b",
                                 $time, exp_r.last, got.last);
                    if (got !== exp_r) errors++;
                end
            end
            // counts cycles with no transaction on either side
            if ((in_valid && in_ready) || (out_valid && out_ready))
                watchdog <= 0;
            else if (watchdog >= STALL_LIMIT)
                timed_out <= 1;
            else
                watchdog <= watchdog + 1;
        end
    end

endmodule
